// ===== rtl/core/torquer_pwm_word_allocator_assert.svh =====
// Assertion macros used by the torquer PWM word allocator job queue (twa_fifo).
`ifndef TORQUER_PWM_WORD_ALLOCATOR_ASSERT_SVH
`define TORQUER_PWM_WORD_ALLOCATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TWA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("torquer allocator assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define TWA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("torquer allocator assertion failed");

`endif

// ===== rtl/core/twa_pkg.sv =====
// Types, constants and divider step function for the torquer PWM word allocator.
package twa_pkg;

  localparam int PERIOD_COUNTS   = 4096;
  localparam int BYTE_BASE       = 256;
  localparam int FULL_FLAG       = 16;
  localparam int FRAC_W          = $clog2(PERIOD_COUNTS);
  localparam int CNT_W           = FRAC_W + 1;
  localparam int CMD_W           = 24;
  localparam int MAG_W           = CMD_W;
  localparam int MM_W            = 23;
  localparam int WORD_W          = 32;
  localparam int STEPS_PER_STAGE = 4;
  localparam int DIV_STAGES      = FRAC_W / STEPS_PER_STAGE;
  localparam int QDEPTH          = 2;
  localparam int QPTR_W          = $clog2(QDEPTH);
  localparam int QCNT_W          = $clog2(QDEPTH + 1);
  localparam int CFG_IDX_W       = 1;

  localparam logic [1:0]        AXIS_Z       = 2'd2;
  localparam logic [MM_W-1:0]   MM_RESET     = MM_W'(65536);
  localparam logic [WORD_W-1:0] OFF_RESET    = 32'h1000_0000;
  localparam logic [WORD_W-1:0] WORD_ALL_ON  = WORD_W'(FULL_FLAG << 8);
  localparam logic [WORD_W-1:0] WORD_ALL_OFF = WORD_W'(FULL_FLAG << 24);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_MOMENT  = 1'b0,
    CFG_OFF_PATTERN = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]              axis;
    logic signed [CMD_W-1:0] command;
    logic                    pos_ok;
    logic                    neg_ok;
  } in_t;

  typedef struct packed {
    logic [WORD_W-1:0] pos_lead_one;
    logic [WORD_W-1:0] pos_lead_two;
    logic [WORD_W-1:0] neg_lead_one;
    logic [WORD_W-1:0] neg_lead_two;
    logic              neg_present;
  } out_t;

  // Classified command waiting for the divider.
  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic [MAG_W-1:0] dvsr;
    logic             pos_ok;
    logic             neg_ok;
    logic             has_neg;
    logic             negative;
    logic             zero;
  } job_t;

  // Divider stage contents.
  typedef struct packed {
    job_t              job;
    logic [MAG_W-1:0]  rem;
    logic [FRAC_W-1:0] quo;
    logic              sat;
  } div_t;

  // Restoring division, STEPS_PER_STAGE quotient bits.
  function automatic div_t div_chunk(div_t s);
    logic [MAG_W:0] r2;
    div_t           o;
    o = s;
    for (int i = 0; i < STEPS_PER_STAGE; i++) begin
      r2 = {o.rem, 1'b0};
      if (r2 >= {1'b0, o.job.dvsr}) begin
        o.rem = MAG_W'(r2 - {1'b0, o.job.dvsr});
        o.quo = {o.quo[FRAC_W-2:0], 1'b1};
      end else begin
        o.rem = r2[MAG_W-1:0];
        o.quo = {o.quo[FRAC_W-2:0], 1'b0};
      end
    end
    return o;
  endfunction

endpackage

// ===== rtl/core/twa_front.sv =====
// Front end: takes axis commands and classifies them into divider jobs.
module twa_front import twa_pkg::*; (
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  in_t             in_data_i,
  input  logic [MM_W-1:0] max_moment_i,
  input  logic            q_full_i,
  output logic            q_push_o,
  output job_t            q_job_o
);

  logic            has_neg;
  logic            neg_ok;
  logic            negative;
  logic [MM_W-1:0] d;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    has_neg  = (in_data_i.axis < AXIS_Z);
    neg_ok   = has_neg && in_data_i.neg_ok;
    negative = in_data_i.command[CMD_W-1];
    // treat a zero full-scale as one
    d        = (max_moment_i == '0) ? MM_W'(1) : max_moment_i;

    q_job_o.mag      = negative ? MAG_W'(-in_data_i.command) : MAG_W'(in_data_i.command);
    // both coils share the dipole: double the divisor
    q_job_o.dvsr     = (in_data_i.pos_ok && neg_ok) ? {d, 1'b0} : {1'b0, d};
    q_job_o.pos_ok   = in_data_i.pos_ok;
    q_job_o.neg_ok   = neg_ok;
    q_job_o.has_neg  = has_neg;
    q_job_o.negative = negative;
    q_job_o.zero     = (in_data_i.command == '0);
  end

endmodule

// ===== rtl/core/twa_fifo.sv =====
// Short job queue between the front end and the divider back end.
`include "torquer_pwm_word_allocator_assert.svh"

module twa_fifo import twa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t data_o
);

  job_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `TWA_ASSERT_SAME(a_no_overflow, clk_i, rst_ni, push_i, !full_o)
  `TWA_ASSERT_SAME(a_no_underflow, clk_i, rst_ni, pop_i, !empty_o)
  `TWA_ASSERT_NEXT(a_count_tracks, clk_i, rst_ni, push_i && !pop_i, !empty_o)

endmodule

// ===== rtl/core/twa_back.sv =====
// Back end: pipelined on-count divider, rounding, clamping and lead packing.
module twa_back import twa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  job_t              q_job_i,
  output logic              q_pop_o,
  input  logic [WORD_W-1:0] off_pattern_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_t              out_data_o
);

  div_t              s_q [DIV_STAGES];
  div_t              s_d [DIV_STAGES];
  logic              v_q [DIV_STAGES];
  logic              load [DIV_STAGES];
  logic              adv [DIV_STAGES];
  logic              in_v [DIV_STAGES];
  div_t              entry;
  logic              out_ready;
  logic              out_valid_q;
  out_t              out_q, out_d;
  div_t              last;
  logic              rnd;
  logic [CNT_W-1:0]  cnt;
  logic [WORD_W-1:0] on_word;
  logic              n_one;

  assign out_ready   = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign q_pop_o     = !q_empty_i && load[0];

  // Stage handshake: a stage loads when empty or when its content moves on.
  always_comb begin
    for (int k = DIV_STAGES - 1; k >= 0; k--) begin
      if (k == DIV_STAGES - 1) begin
        adv[k] = v_q[k] && out_ready;
      end else begin
        adv[k] = v_q[k] && load[(k == DIV_STAGES - 1) ? k : k + 1];
      end
      load[k] = !v_q[k] || adv[k];
    end
    for (int k = 0; k < DIV_STAGES; k++) begin
      in_v[k] = (k == 0) ? (!q_empty_i && load[0]) : adv[(k == 0) ? 0 : k - 1];
    end
  end

  always_comb begin
    entry.job = q_job_i;
    entry.sat = (q_job_i.mag >= q_job_i.dvsr);
    entry.rem = entry.sat ? '0 : q_job_i.mag;
    entry.quo = '0;
    for (int k = 0; k < DIV_STAGES; k++) begin
      s_d[k] = div_chunk((k == 0) ? entry : s_q[(k == 0) ? 0 : k - 1]);
    end
  end

  // Round half up on the remainder, clamp and pack.
  always_comb begin
    last = s_q[DIV_STAGES-1];
    rnd  = ({last.rem, 1'b0} >= {1'b0, last.job.dvsr});
    cnt  = last.sat ? CNT_W'(PERIOD_COUNTS) : {1'b0, last.quo} + CNT_W'(rnd);
    if (cnt >= CNT_W'(PERIOD_COUNTS)) begin
      on_word = WORD_ALL_ON;
    end else if (cnt == '0) begin
      on_word = WORD_ALL_OFF;
    end else begin
      on_word = {8'(cnt / BYTE_BASE), 8'(cnt % BYTE_BASE), 16'h0000};
    end

    // negative coil share is the negated command
    n_one = last.job.negative || last.job.zero;

    out_d.pos_lead_one = (last.job.pos_ok && !last.job.negative) ? on_word : off_pattern_i;
    out_d.pos_lead_two = (last.job.pos_ok && last.job.negative) ? on_word : off_pattern_i;
    out_d.neg_lead_one = (last.job.neg_ok && n_one) ? on_word : off_pattern_i;
    out_d.neg_lead_two = (last.job.neg_ok && !n_one) ? on_word : off_pattern_i;
    out_d.neg_present  = last.job.has_neg;
    if (!last.job.has_neg) begin
      out_d.neg_lead_one = '0;
      out_d.neg_lead_two = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        v_q[k] <= 1'b0;
      end
      out_valid_q <= 1'b0;
    end else begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        if (load[k]) begin
          v_q[k] <= in_v[k];
        end
      end
      if (out_ready) begin
        out_valid_q <= v_q[DIV_STAGES-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (load[k] && in_v[k]) begin
        s_q[k] <= s_d[k];
      end
    end
    if (adv[DIV_STAGES-1]) begin
      out_q <= out_d;
    end
  end

endmodule

// ===== rtl/core/torquer_pwm_word_allocator.sv =====
// Path: a command passes the queue, 3 restoring divider stages of 4 quotient bits each
//   and the output register before its result is offered; an output stall holds them.
// Throughput: one command per cycle unless stalled; the pipelined divider sets the depth.
// Reset: max_moment returns to 65536, off_pattern to 0x10000000; queue and pipeline empty.
// Top level of the torquer PWM word allocator: configuration registers and wiring.
module torquer_pwm_word_allocator import twa_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_t                  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_t                 out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  cfg_idx_e             cfg_index_i,
  input  logic [WORD_W-1:0]    cfg_data_i
);

  logic [MM_W-1:0]   max_moment_q;
  logic [WORD_W-1:0] off_pattern_q;
  logic              q_full;
  logic              q_empty;
  logic              q_push;
  logic              q_pop;
  job_t              q_wr_job;
  job_t              q_rd_job;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_moment_q  <= MM_RESET;
      off_pattern_q <= OFF_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MAX_MOMENT:  max_moment_q  <= cfg_data_i[MM_W-1:0];
        CFG_OFF_PATTERN: off_pattern_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  twa_front u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .max_moment_i (max_moment_q),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_job_o      (q_wr_job)
  );

  twa_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wr_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_rd_job)
  );

  twa_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_job_i       (q_rd_job),
    .q_pop_o       (q_pop),
    .off_pattern_i (off_pattern_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_o    (out_data_o)
  );

endmodule
